// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ecal_pkg.sv =====
package ecal_pkg;

  localparam int EPOCH_BITS  = 36;
  localparam int DIV_SHIFT   = 7;
  localparam int NUM_W       = EPOCH_BITS - DIV_SHIFT;
  localparam int DAYS_W      = EPOCH_BITS - 16;
  localparam int DIV_W       = 10;
  localparam int RECIP_SHIFT = NUM_W + DIV_W;
  localparam int RECIP_W     = NUM_W + 1;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int YEAR_W      = 13;
  localparam int MONTH_W     = 4;
  localparam int DAY_W       = 5;
  localparam int YLEN_W      = 9;
  localparam int MLEN_W      = 5;
  localparam int MOD400_W    = 9;

  localparam logic [DIV_W-1:0]    DIV_CONST    = 10'd675;
  localparam logic [63:0]         RECIP_FULL   =
    ((64'd1 << RECIP_SHIFT) + 64'(DIV_CONST) - 64'd1) / 64'(DIV_CONST);
  localparam logic [RECIP_W-1:0]  RECIP        = RECIP_FULL[RECIP_W-1:0];
  localparam logic [YEAR_W-1:0]   BASE_YEAR    = 13'd1970;
  localparam logic [MOD400_W-1:0] BASE_MOD400  = 9'd370;
  localparam logic [MOD400_W-1:0] MOD400_LAST  = 9'd399;
  localparam logic [MOD400_W-1:0] CENTURY_1    = 9'd100;
  localparam logic [MOD400_W-1:0] CENTURY_2    = 9'd200;
  localparam logic [MOD400_W-1:0] CENTURY_3    = 9'd300;
  localparam logic [YLEN_W-1:0]   DAYS_LEAP    = 9'd366;
  localparam logic [YLEN_W-1:0]   DAYS_COMMON  = 9'd365;
  localparam logic [MONTH_W-1:0]  MONTH_JAN    = 4'd1;
  localparam logic [MONTH_W-1:0]  MONTH_FEB    = 4'd2;
  localparam logic [MONTH_W-1:0]  MONTH_JUL    = 4'd7;
  localparam logic [MONTH_W-1:0]  MONTH_DEC    = 4'd12;
  localparam logic [MLEN_W-1:0]   LEN_FEB_LEAP = 5'd29;
  localparam logic [MLEN_W-1:0]   LEN_FEB      = 5'd28;
  localparam logic [MLEN_W-1:0]   LEN_LONG     = 5'd31;
  localparam logic [MLEN_W-1:0]   LEN_SHORT    = 5'd30;

  typedef struct packed {
    logic start;
    logic divide;
    logic year_step;
    logic month_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
  } sts_t;

  function automatic logic is_leap(logic [1:0] year_low, logic [MOD400_W-1:0] mod400);
    return (year_low == 2'b00) && (mod400 != CENTURY_1) && (mod400 != CENTURY_2) &&
           (mod400 != CENTURY_3);
  endfunction

  function automatic logic [MLEN_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
    logic [MLEN_W-1:0] len;
    if (m == MONTH_FEB) begin
      len = leap ? LEN_FEB_LEAP : LEN_FEB;
    end else if (m <= MONTH_JUL) begin
      len = m[0] ? LEN_LONG : LEN_SHORT;
    end else begin
      len = m[0] ? LEN_SHORT : LEN_LONG;
    end
    return len;
  endfunction

endpackage

// ===== rtl/ecal_ctrl.sv =====
`include "assert_macros.svh"

module ecal_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ecal_pkg::cmd_t cmd_o,
  input  ecal_pkg::sts_t sts_i
);
  import ecal_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_YEAR  = 3'd2;
  localparam logic [2:0] ST_MONTH = 3'd3;
  localparam logic [2:0] ST_HOLD  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             out_free;
  logic [4:0]       cmd_vec;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.divide = 1'b1;
        state_d      = ST_YEAR;
      end
      ST_YEAR: begin
        if (sts_i.year_done) begin
          state_d = ST_MONTH;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        if (!sts_i.month_done) begin
          cmd_o.month_step = 1'b1;
        end else if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_vec = {cmd_o.start, cmd_o.divide, cmd_o.year_step, cmd_o.month_step,
                    cmd_o.load_out};

  `ASSERT_AT(a_cmd_exclusive, clk_i, rst_ni, $onehot0(cmd_vec), "commands overlap")
  `ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, cmd_o.load_out, out_free, "pending result overwritten")
  `ASSERT_NEXT(a_start_div, clk_i, rst_ni, accept, state_q == ST_DIV, "transfer did not start divide")
  `ASSERT_NEXT(a_div_to_year, clk_i, rst_ni, cmd_o.divide, state_q == ST_YEAR, "divide end lost")

endmodule

// ===== rtl/ecal_dp.sv =====
module ecal_dp (
  input  logic                            clk_i,
  input  ecal_pkg::cmd_t                  cmd_i,
  output ecal_pkg::sts_t                  sts_o,
  input  logic [ecal_pkg::EPOCH_BITS-1:0] epoch_seconds_i,
  output logic [ecal_pkg::YEAR_W-1:0]     year_o,
  output logic [ecal_pkg::MONTH_W-1:0]    month_o,
  output logic [ecal_pkg::DAY_W-1:0]      day_o
);
  import ecal_pkg::*;

  logic [NUM_W-1:0]     num_q, num_d;
  logic [PROD_W-1:0]    prod;
  logic [DAYS_W-1:0]    days_q, days_d;
  logic [YEAR_W-1:0]    year_q, year_d;
  logic [MOD400_W-1:0]  mod400_q, mod400_d;
  logic [MONTH_W-1:0]   month_q, month_d;
  logic                 leap;
  logic [YLEN_W-1:0]    ylen;
  logic [MLEN_W-1:0]    mlen;
  logic [YEAR_W-1:0]    year_out_q;
  logic [MONTH_W-1:0]   month_out_q;
  logic [DAY_W-1:0]     day_out_q;

  // Divide by 675 through the rounded-up reciprocal, exact over the whole numerator range
  assign prod = PROD_W'(num_q) * PROD_W'(RECIP);

  assign leap = is_leap(year_q[1:0], mod400_q);
  assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
  assign mlen = month_len(month_q, leap);

  assign sts_o.year_done  = (days_q < DAYS_W'(ylen));
  assign sts_o.month_done = (month_q == MONTH_DEC) || (days_q < DAYS_W'(mlen));

  always_comb begin
    num_d    = num_q;
    days_d   = days_q;
    year_d   = year_q;
    mod400_d = mod400_q;
    month_d  = month_q;
    if (cmd_i.start) begin
      num_d    = epoch_seconds_i[EPOCH_BITS-1:DIV_SHIFT];
      year_d   = BASE_YEAR;
      mod400_d = BASE_MOD400;
      month_d  = MONTH_JAN;
    end
    if (cmd_i.divide) begin
      days_d = prod[RECIP_SHIFT +: DAYS_W];
    end
    if (cmd_i.year_step) begin
      days_d   = days_q - DAYS_W'(ylen);
      year_d   = year_q + YEAR_W'(1);
      mod400_d = (mod400_q == MOD400_LAST) ? '0 : mod400_q + MOD400_W'(1);
    end
    if (cmd_i.month_step) begin
      days_d  = days_q - DAYS_W'(mlen);
      month_d = month_q + MONTH_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    days_q   <= days_d;
    year_q   <= year_d;
    mod400_q <= mod400_d;
    month_q  <= month_d;
    if (cmd_i.load_out) begin
      year_out_q  <= year_q;
      month_out_q <= month_q;
      day_out_q   <= days_q[DAY_W-1:0] + DAY_W'(1);
    end
  end

  assign year_o  = year_out_q;
  assign month_o = month_out_q;
  assign day_o   = day_out_q;

endmodule

// ===== rtl/epoch_seconds_to_calendar_date_unit.sv =====
// Sequence: a reciprocal multiply for the divide by 86400, then a one-year-per-cycle step
// loop and a one-month-per-cycle loop; the result then enters the output register.
// Throughput: one item in flight; the next input transfer is taken the cycle after
// the result enters the output register, which holds it while the sink stalls.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
module epoch_seconds_to_calendar_date_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ecal_pkg::EPOCH_BITS-1:0] epoch_seconds_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ecal_pkg::YEAR_W-1:0]     year_o,
  output logic [ecal_pkg::MONTH_W-1:0]    month_o,
  output logic [ecal_pkg::DAY_W-1:0]      day_o
);
  import ecal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ecal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  ecal_dp u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .epoch_seconds_i(epoch_seconds_i),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_o          (day_o)
  );

endmodule
